@@ hw/rtl/spc_pkg.sv @@
`default_nettype none

package spc_pkg;

  // Width of the configuration write word (pass-through mode bit)
  localparam int unsigned CFG_WIDTH = 1;

  typedef logic [CFG_WIDTH-1:0] cfg_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/spc_intf.sv @@
`default_nettype none

// Profile sample stream
interface spc_sample_if #(
  parameter int unsigned MZ_WIDTH        = 32,
  parameter int unsigned INTENSITY_WIDTH = 32
) ();
  logic                       valid;
  logic                       ready;
  logic [MZ_WIDTH-1:0]        sample_mz;
  logic [INTENSITY_WIDTH-1:0] sample_intensity;
  logic                       spectrum_end;

  modport source (output valid, sample_mz, sample_intensity, spectrum_end, input ready);
  modport sink   (input valid, sample_mz, sample_intensity, spectrum_end, output ready);
endinterface

// Centroid result stream
interface spc_centroid_if #(
  parameter int unsigned MZ_WIDTH  = 32,
  parameter int unsigned SUM_WIDTH = 48
) ();
  logic                 valid;
  logic                 ready;
  logic [MZ_WIDTH-1:0]  centroid_mz;
  logic [SUM_WIDTH-1:0] centroid_intensity;
  logic                 end_of_spectrum;
  logic                 last_of_run;

  modport source (output valid, centroid_mz, centroid_intensity, end_of_spectrum,
                  last_of_run, input ready);
  modport sink   (input valid, centroid_mz, centroid_intensity, end_of_spectrum,
                  last_of_run, output ready);
endinterface

// Configuration write channel (pass-through register)
interface spc_cfg_if import spc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t wdata;

  modport source (output valid, wdata, input ready);
  modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/spectrum_peak_centroider.sv @@
// A centroiding sample passes through a bit-serial multiply (one multiplier bit per cycle over
// MUL_W bits) and a restoring divide (one quotient bit per cycle) before the next sample is taken.
// Zero-weight samples skip both, and pass-through samples skip the peak logic; a restart peak or
// an end flush adds a state (ST_PEAK or ST_FLUSH), and each result also waits until the output
// register is free.
// One output register, a sample is taken while a result waits there; reset is asynchronous,
// active low, and clears the peak state and mode at once.
`default_nettype none

module spectrum_peak_centroider import spc_pkg::*; #(
  parameter int unsigned MZ_WIDTH        = 32,
  parameter int unsigned INTENSITY_WIDTH = 32,
  parameter int unsigned SUM_WIDTH       = 48
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  spc_cfg_if.sink        cfg_i,
  spc_sample_if.sink     sample_i,
  spc_centroid_if.source centroid_o
);

  localparam int unsigned MUL_W   = (SUM_WIDTH > INTENSITY_WIDTH) ? SUM_WIDTH : INTENSITY_WIDTH;
  localparam int unsigned DEN_W   = MUL_W + 1;
  localparam int unsigned NUM_W   = MZ_WIDTH + DEN_W;
  localparam int unsigned CNT_MAX = (MUL_W > MZ_WIDTH) ? MUL_W : MZ_WIDTH;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_PEAK,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FLUSH
  } state_e;

  // Control and peak state
  state_e                     state_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       out_valid_q;
  cfg_word_t                  pass_q;
  logic                       rising_q;
  logic [INTENSITY_WIDTH-1:0] prior_q;
  logic [MZ_WIDTH-1:0]        peak_mz_q;
  logic [SUM_WIDTH-1:0]       peak_sum_q;

  // Datapath registers
  logic [MZ_WIDTH-1:0]        mz_q;
  logic [INTENSITY_WIDTH-1:0] inten_q;
  logic                       eos_q;
  logic [MUL_W-1:0]           m1_q;
  logic [MUL_W-1:0]           m2_q;
  logic [NUM_W-1:0]           prod_q;
  logic [DEN_W-1:0]           den_q;
  logic [MZ_WIDTH-1:0]        out_mz_q;
  logic [SUM_WIDTH-1:0]       out_int_q;
  logic                       out_eos_q;
  logic                       out_last_q;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  falling;
  logic [DEN_W-1:0]      den_sum_d;
  logic [MZ_WIDTH:0]     mul_addend;
  logic [MZ_WIDTH+1:0]   mul_hi;
  logic [NUM_W-1:0]      mul_p_d;
  logic [DEN_W:0]        div_shift;
  logic [DEN_W+1:0]      div_diff;
  logic                  div_ge;
  logic [DEN_W-1:0]      div_rem;
  logic [NUM_W-1:0]      div_p_d;
  logic [SUM_WIDTH-1:0]  sum_sat;

  // Handshakes
  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || centroid_o.ready;
  assign out_load       = out_free &&
                          ((state_q == ST_PASS) || (state_q == ST_PEAK) || (state_q == ST_FLUSH));

  assign centroid_o.valid              = out_valid_q;
  assign centroid_o.centroid_mz        = out_mz_q;
  assign centroid_o.centroid_intensity = out_int_q;
  assign centroid_o.end_of_spectrum    = out_eos_q;
  assign centroid_o.last_of_run        = out_last_q;

  // Peak boundary detection on the incoming sample
  assign falling   = sample_i.sample_intensity < prior_q;
  assign den_sum_d = DEN_W'(peak_sum_q) + DEN_W'(inten_q);

  // Bit-serial multiply-accumulate: mean*sum + mz*intensity, one bit per cycle
  always_comb begin
    mul_addend = ({1'b0, (m1_q[0] ? peak_mz_q : '0)}) + ({1'b0, (m2_q[0] ? mz_q : '0)});
    mul_hi     = {1'b0, prod_q[NUM_W-1:MUL_W]} + {1'b0, mul_addend};
    mul_p_d    = {mul_hi, prod_q[MUL_W-1:1]};
  end

  // Restoring divide: remainder in the upper part, quotient shifts into the low part
  always_comb begin
    div_shift = {prod_q[NUM_W-1:MZ_WIDTH], prod_q[MZ_WIDTH-1]};
    div_diff  = {1'b0, div_shift} - {2'b00, den_q};
    div_ge    = !div_diff[DEN_W+1];
    div_rem   = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
    div_p_d   = {div_rem, prod_q[MZ_WIDTH-2:0], div_ge};
  end

  // Saturate the new running sum
  assign sum_sat = (|den_q[DEN_W-1:SUM_WIDTH]) ? '1 : den_q[SUM_WIDTH-1:0];

  // State machine, peak state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
      rising_q    <= 1'b1;
      prior_q     <= '0;
      peak_mz_q   <= '0;
      peak_sum_q  <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        pass_q <= cfg_i.wdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (centroid_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (pass_q[0]) begin
              state_q <= ST_PASS;
            end else begin
              prior_q <= sample_i.sample_intensity;
              if (falling) begin
                rising_q <= 1'b0;
                state_q  <= ST_LOAD;
              end else begin
                rising_q <= 1'b1;
                if (!rising_q && (peak_sum_q != '0)) begin
                  state_q <= ST_PEAK;
                end else begin
                  state_q <= ST_LOAD;
                end
              end
            end
          end
        end
        ST_PASS: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            if (eos_q) begin
              rising_q   <= 1'b1;
              prior_q    <= '0;
              peak_mz_q  <= '0;
              peak_sum_q <= '0;
            end
          end
        end
        ST_PEAK: begin
          // emit the finished peak, then restart the sum
          if (out_free) begin
            peak_sum_q <= '0;
            state_q    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q <= '0;
          if (den_sum_d == '0) begin
            state_q <= eos_q ? ST_FLUSH : ST_IDLE;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_q == CNT_W'(MUL_W - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(MZ_WIDTH - 1)) begin
            cnt_q      <= '0;
            peak_mz_q  <= div_p_d[MZ_WIDTH-1:0];
            peak_sum_q <= sum_sat;
            state_q    <= eos_q ? ST_FLUSH : ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FLUSH: begin
          // emit the pending peak or an empty end marker, then clear
          if (out_free) begin
            rising_q   <= 1'b1;
            prior_q    <= '0;
            peak_mz_q  <= '0;
            peak_sum_q <= '0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample capture, serial datapath and output payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mz_q    <= sample_i.sample_mz;
          inten_q <= sample_i.sample_intensity;
          eos_q   <= sample_i.spectrum_end;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_mz_q   <= mz_q;
          out_int_q  <= SUM_WIDTH'(inten_q);
          out_eos_q  <= eos_q;
          out_last_q <= 1'b1;
        end
      end
      ST_PEAK: begin
        if (out_free) begin
          out_mz_q   <= peak_mz_q;
          out_int_q  <= peak_sum_q;
          out_eos_q  <= 1'b0;
          out_last_q <= !eos_q;
        end
      end
      ST_LOAD: begin
        m1_q   <= MUL_W'(peak_sum_q);
        m2_q   <= MUL_W'(inten_q);
        prod_q <= '0;
        den_q  <= den_sum_d;
      end
      ST_MUL: begin
        m1_q   <= m1_q >> 1;
        m2_q   <= m2_q >> 1;
        prod_q <= mul_p_d;
      end
      ST_DIV: begin
        prod_q <= div_p_d;
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_mz_q   <= (peak_sum_q != '0) ? peak_mz_q : '0;
          out_int_q  <= peak_sum_q;
          out_eos_q  <= 1'b1;
          out_last_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // A restart peak is only emitted when it carries weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEAK) |-> (peak_sum_q != '0))
    else $error("restart peak emitted with zero sum");

  // The remainder stays below the divisor throughout the divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (prod_q[NUM_W-1:MZ_WIDTH] < den_q))
    else $error("divide remainder out of range, quotient overflow");

  // Flushing a spectrum returns the peak state to its cleared value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free) |=>
      (peak_sum_q == '0 && rising_q && prior_q == '0))
    else $error("peak state not cleared after spectrum flush");

  // The end-of-spectrum result is always the last one of its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (centroid_o.valid && centroid_o.end_of_spectrum) |-> centroid_o.last_of_run)
    else $error("end of spectrum without last_of_run");
`endif

endmodule

`default_nettype wire

@@ tb/spc_centroid_checker.sv @@
module spc_centroid_checker import spc_pkg::*; #(
  parameter int unsigned MZ_WIDTH        = 32,
  parameter int unsigned INTENSITY_WIDTH = 32,
  parameter int unsigned SUM_WIDTH       = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spc_cfg_if          cfg_mon,
  spc_sample_if       sample_mon,
  spc_centroid_if     centroid_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PRINTS = 100;

  typedef struct packed {
    logic [MZ_WIDTH-1:0]  mz;
    logic [SUM_WIDTH-1:0] intensity;
    logic                 eos;
    logic                 last;
  } centroid_t;

  // Centroids still owed by the block, oldest first
  centroid_t centroids_due[$];

  // Shadow of the peak tracker and the mode register
  logic                       echo_mode;
  logic                       rising;
  logic [INTENSITY_WIDTH-1:0] prior_level;
  logic [MZ_WIDTH-1:0]        mean_mz;
  logic [SUM_WIDTH-1:0]       weight_sum;

  int unsigned errors_n;
  int unsigned results_n;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    errors_n++;
    if (errors_n <= MAX_PRINTS) begin
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
    end
  endtask

  task automatic clear_peak();
    rising      = 1'b1;
    prior_level = '0;
    mean_mz     = '0;
    weight_sum  = '0;
  endtask

  // Work out the centroids that one sample releases and queue them
  task automatic predict_centroids(input logic [MZ_WIDTH-1:0] mz,
                                   input logic [INTENSITY_WIDTH-1:0] level,
                                   input logic eos);
    centroid_t          made [2];
    int unsigned        n_made;
    logic [SUM_WIDTH:0] grown;
    logic [127:0]       num;
    n_made = 0;
    if (echo_mode) begin
      made[0] = '{mz: mz, intensity: SUM_WIDTH'(level), eos: eos, last: 1'b0};
      n_made  = 1;
      if (eos) clear_peak();
    end else begin
      // A rise after a fall closes the peak gathered so far
      if (level < prior_level) begin
        rising = 1'b0;
      end else begin
        if (!rising) begin
          if (weight_sum != '0) begin
            made[n_made] = '{mz: mean_mz, intensity: weight_sum, eos: 1'b0, last: 1'b0};
            n_made++;
          end
          weight_sum = '0;
        end
        rising = 1'b1;
      end
      // Fold the sample into the weighted mean; hold the mean on zero weight
      grown = {1'b0, weight_sum} + (SUM_WIDTH+1)'(level);
      if (grown != '0) begin
        num        = 128'(mean_mz) * 128'(weight_sum) + 128'(mz) * 128'(level);
        mean_mz    = MZ_WIDTH'(num / 128'(grown));
        weight_sum = grown[SUM_WIDTH] ? '1 : grown[SUM_WIDTH-1:0];
      end
      prior_level = level;
      // Flush at spectrum end, with an empty marker when nothing is gathered
      if (eos) begin
        if (weight_sum != '0) begin
          made[n_made] = '{mz: mean_mz, intensity: weight_sum, eos: 1'b1, last: 1'b0};
        end else begin
          made[n_made] = '{mz: '0, intensity: '0, eos: 1'b1, last: 1'b0};
        end
        n_made++;
        clear_peak();
      end
    end
    for (int unsigned k = 0; k < n_made; k++) begin
      if (k == n_made - 1) made[k].last = 1'b1;
      centroids_due.insert(centroids_due.size(), made[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    centroid_t got;
    centroid_t want;
    if (!rst_ni) begin
      centroids_due.delete();
      echo_mode = 1'b0;
      clear_peak();
      errors_n  = 0;
      results_n = 0;
    end else begin
      // Track the mode register
      if (cfg_mon.valid && cfg_mon.ready) begin
        echo_mode = cfg_mon.wdata[0];
      end
      // Compare each result transfer with the oldest owed centroid
      if (centroid_mon.valid && centroid_mon.ready) begin
        got = '{mz: centroid_mon.centroid_mz, intensity: centroid_mon.centroid_intensity,
                eos: centroid_mon.end_of_spectrum, last: centroid_mon.last_of_run};
        results_n++;
        if (centroids_due.size() == 0) begin
          report("unowed centroid, centroid_mz", 64'(got.mz), 64'(0));
        end else begin
          want = centroids_due.pop_front();
          if (got.mz !== want.mz) report("centroid_mz", 64'(got.mz), 64'(want.mz));
          if (got.intensity !== want.intensity) begin
            report("centroid_intensity", 64'(got.intensity), 64'(want.intensity));
          end
          if (got.eos !== want.eos) report("end_of_spectrum", 64'(got.eos), 64'(want.eos));
          if (got.last !== want.last) report("last_of_run", 64'(got.last), 64'(want.last));
        end
      end
      // Predict from each sample transfer
      if (sample_mon.valid && sample_mon.ready) begin
        predict_centroids(sample_mon.sample_mz, sample_mon.sample_intensity,
                          sample_mon.spectrum_end);
      end
    end
    errors_o  <= errors_n;
    pending_o <= centroids_due.size();
    results_o <= results_n;
  end

endmodule

@@ tb/tb_spectrum_peak_centroider.sv @@
module tb_spectrum_peak_centroider;
  import spc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MZ_W          = 32;
  localparam int unsigned INT_W         = 32;
  localparam int unsigned SUM_W         = 48;
  localparam int unsigned HOLD_CYCLES   = 6000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned ITEM_TARGET   = 1050;

  localparam cfg_word_t PEAK_MODE = 1'b0;
  localparam cfg_word_t ECHO_MODE = 1'b1;

  logic clk;
  logic rst_n;

  // Shared by the sender and the receiver process
  logic        steady;
  int unsigned hold_requests;

  int unsigned n_sent;
  int unsigned n_spectra;
  int unsigned n_mode_writes;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned checked_count;

  spc_cfg_if cfg_if ();
  spc_sample_if #(.MZ_WIDTH(MZ_W), .INTENSITY_WIDTH(INT_W)) sample_if ();
  spc_centroid_if #(.MZ_WIDTH(MZ_W), .SUM_WIDTH(SUM_W)) centroid_if ();

  spectrum_peak_centroider #(
    .MZ_WIDTH(MZ_W),
    .INTENSITY_WIDTH(INT_W),
    .SUM_WIDTH(SUM_W)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_i(cfg_if),
    .sample_i(sample_if),
    .centroid_o(centroid_if)
  );

  spc_centroid_checker #(
    .MZ_WIDTH(MZ_W),
    .INTENSITY_WIDTH(INT_W),
    .SUM_WIDTH(SUM_W)
  ) checker_i (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_mon(cfg_if),
    .sample_mon(sample_if),
    .centroid_mon(centroid_if),
    .errors_o(fail_count),
    .pending_o(due_count),
    .results_o(checked_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up on a hung run
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin : rx_side
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    centroid_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        centroid_if.ready <= 1'b0;
      end else begin
        centroid_if.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Offer one sample after an optional gap and hold it until the transfer
  task automatic send_sample(input logic [MZ_W-1:0] mz, input logic [INT_W-1:0] level,
                             input logic eos);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? $urandom_range(1, 100) : 0;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid            <= 1'b1;
    sample_if.sample_mz        <= mz;
    sample_if.sample_intensity <= level;
    sample_if.spectrum_end     <= eos;
    do @(posedge clk); while (!sample_if.ready);
    n_sent++;
    if (eos) n_spectra++;
  endtask

  // Random spectrum of rising and falling peaks, with some noise samples
  task automatic send_spectrum(input int unsigned len);
    logic [MZ_W-1:0]  mz;
    logic [INT_W-1:0] level;
    logic [INT_W-1:0] span;
    logic [INT_W-1:0] step;
    logic             climbing;
    mz = $urandom;
    case ($urandom_range(0, 3))
      0: span = 32'h0000_000F;
      1: span = 32'h0000_FFFF;
      2: span = 32'h00FF_FFFF;
      default: span = 32'hFFFF_FFFF;
    endcase
    level    = $urandom & span;
    climbing = 1'b1;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        level = $urandom;
      end else begin
        if ($urandom_range(0, 3) == 0) climbing = !climbing;
        step = $urandom & (span >> $urandom_range(0, 3));
        if (climbing) begin
          level = (level > span - step) ? span : level + step;
        end else begin
          level = (level < step) ? '0 : level - step;
        end
      end
      if ($urandom_range(0, 11) == 0) level = '0;
      send_sample(mz, level, k == len - 1);
      mz = mz + $urandom_range(1, 2048);
    end
  endtask

  task automatic send_spectra_until(input int unsigned target);
    while (n_sent < target) begin
      send_spectrum($urandom_range(1, 14));
    end
  endtask

  // Stop offering, wait for every owed centroid, then let the block settle
  task automatic wait_for_results();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input cfg_word_t mode);
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_mode_writes++;
  endtask

  initial begin : stimulus
    int unsigned waited;
    n_sent        = 0;
    n_spectra     = 0;
    n_mode_writes = 0;
    rst_n                      <= 1'b0;
    steady                     <= 1'b0;
    hold_requests              <= 0;
    cfg_if.valid               <= 1'b0;
    cfg_if.wdata               <= PEAK_MODE;
    sample_if.valid            <= 1'b0;
    sample_if.sample_mz        <= '0;
    sample_if.sample_intensity <= '0;
    sample_if.spectrum_end     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(PEAK_MODE);

    // Lone zero sample: empty end marker
    send_sample(32'h0064_0000, 32'd0, 1'b1);
    // Zero-weight samples leave the mean alone
    send_sample(32'h0064_0000, 32'd0, 1'b0);
    send_sample(32'h0065_0000, 32'd0, 1'b0);
    send_sample(32'h0066_0000, 32'd7, 1'b1);
    // Rise on the last sample: finished peak, then the end flush
    send_sample(32'h00C8_0000, 32'd10, 1'b0);
    send_sample(32'h00C9_0000, 32'd50, 1'b0);
    send_sample(32'h00CA_0000, 32'd20, 1'b0);
    send_sample(32'h00CB_0000, 32'd30, 1'b1);
    // Equal intensities count as rising
    send_sample(32'h012C_0000, 32'd5, 1'b0);
    send_sample(32'h012D_0000, 32'd5, 1'b0);
    send_sample(32'h012E_0000, 32'd5, 1'b1);
    // Field extremes
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // Mode switch in the middle of a spectrum
    send_sample(32'h0190_0000, 32'd100, 1'b0);
    send_sample(32'h0191_0000, 32'd40, 1'b0);
    wait_for_results();
    write_mode(ECHO_MODE);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    wait_for_results();
    write_mode(PEAK_MODE);
    send_sample(32'h0192_0000, 32'd90, 1'b1);
    // Echoed spectrum end clears a pending peak
    send_sample(32'h0300_0000, 32'd8, 1'b0);
    wait_for_results();
    write_mode(ECHO_MODE);
    send_sample(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    wait_for_results();
    write_mode(PEAK_MODE);
    send_sample(32'h0301_0000, 32'd4, 1'b1);

    // Random peaks with idling on both sides
    send_spectra_until(n_sent + 350);
    // Run without any idling
    steady <= 1'b1;
    send_spectra_until(n_sent + 150);
    steady <= 1'b0;
    // Hold the result side off while samples keep coming
    hold_requests <= hold_requests + 1;
    send_spectra_until(n_sent + 24);
    // Pause the sender until every centroid is back
    wait_for_results();
    send_spectra_until(n_sent + 150);
    // Already-centroided spectra echoed through
    wait_for_results();
    write_mode(ECHO_MODE);
    send_spectra_until(n_sent + 180);
    wait_for_results();
    write_mode(PEAK_MODE);
    send_spectra_until(ITEM_TARGET + 23);

    // Drain and settle
    sample_if.valid <= 1'b0;
    @(posedge clk);
    for (waited = 0; due_count != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d spectra over %0d mode writes, peak and echo modes.",
             n_sent, n_spectra, n_mode_writes);
    $display("Checked %0d centroids, %0d still owed, %0d mismatches.",
             checked_count, due_count, fail_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/spc_pkg.sv
hw/rtl/spc_intf.sv
hw/rtl/spectrum_peak_centroider.sv
tb/spc_centroid_checker.sv
tb/tb_spectrum_peak_centroider.sv
